// File: rtl/core/cda_pkg.sv
`timescale 1ns / 1ps

package cda_pkg;

    // Input mode codes
    localparam logic [2:0] MODE_DAYS    = 3'd0;
    localparam logic [2:0] MODE_WEEKS   = 3'd1;
    localparam logic [2:0] MODE_MONTHS  = 3'd2;
    localparam logic [2:0] MODE_YEARS   = 3'd3;
    localparam logic [2:0] MODE_DECADES = 3'd4;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [15:0] YEAR_MAX = 16'hFFFF;

    // Month lengths, January first, February for a common year
    localparam logic [4:0] MONTH_DAYS [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // y divisible by 25 <=> (y * inv(25) mod 2^16) <= floor(65535 / 25)
    localparam logic [15:0] INV25_MOD16 = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DAYS,
        ST_MONTHS,
        ST_FIN
    } cda_state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic day_step;
        logic month_step;
        logic out_load;
    } cda_cmd_t;

    typedef struct packed {
        logic invalid;
        logic mode_days;
        logic mode_months;
        logic rem_zero;
        logic rem_one;
        logic day_fit;
    } cda_sts_t;

    // Gregorian leap test: div by 4, and not by 100 unless by 400 (= 16 * 25)
    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        prod  = {16'd0, y} * {16'd0, INV25_MOD16};
        div25 = (prod[15:0] <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    // Zero for an invalid month
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [3:0] idx;
        idx = m - 4'd1;
        if ((m == 4'd0) || (m > MONTH_DEC))
            return 5'd0;
        else if (m == MONTH_FEB)
            return leap ? 5'd29 : 5'd28;
        else
            return MONTH_DAYS[idx];
    endfunction

endpackage

// File: rtl/core/calendar_date_adder.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid/tready/tdata[47:0]/tuser  date, amount; tuser = mode
// m_axis    out  tvalid/tready/tdata[31:0]/tuser  result date; tuser = flags
//
// Sequence: accept, a settle state, a check state, then for day/week modes one
// step per month boundary crossed plus one for the last partial month, or for
// month mode one step per month added, then the load of the output register.
// Year/decade/undefined modes, bad dates and zero amounts skip the step states.
// Reset: rst_n asynchronous, clears the controller and the output valid only.
// Stalls: one transaction in flight; the next input is taken once the result
// is in the output register, even if m_axis_tready is low.

module calendar_date_adder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // amount[15:0], day_in[20:16], month_in[24:21],
                                        // year_in[40:25], zero fill
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // day_out[4:0], month_out[8:5], year_out[24:9],
                                        // zero fill
    output logic [1:0]  m_axis_tuser    // bad_date[0], year_overflow[1]
);

    cda_pkg::cda_cmd_t cmd;
    cda_pkg::cda_sts_t sts;

    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic        bad_date;
    logic        year_overflow;

    // Sequencer: load, check, step, hand over to output register
    cda_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    // Date registers, month-length lookup, step arithmetic, output register
    cda_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (s_axis_tuser),
        .amount        (s_axis_tdata[15:0]),
        .day_in        (s_axis_tdata[20:16]),
        .month_in      (s_axis_tdata[24:21]),
        .year_in       (s_axis_tdata[40:25]),
        .day_out       (day_out),
        .month_out     (month_out),
        .year_out      (year_out),
        .bad_date      (bad_date),
        .year_overflow (year_overflow)
    );

    // Pack result fields, lowest field in the lowest bits
    assign m_axis_tdata = {7'd0, year_out, month_out, day_out};
    assign m_axis_tuser = {year_overflow, bad_date};

endmodule

// File: rtl/core/cda_datapath.sv
`timescale 1ns / 1ps

module cda_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  cda_pkg::cda_cmd_t cmd,
    output cda_pkg::cda_sts_t sts,
    input  logic [2:0]       mode,
    input  logic [15:0]      amount,
    input  logic [4:0]       day_in,
    input  logic [3:0]       month_in,
    input  logic [15:0]      year_in,
    output logic [4:0]       day_out,
    output logic [3:0]       month_out,
    output logic [15:0]      year_out,
    output logic             bad_date,
    output logic             year_overflow
);

    logic [2:0]  mode_reg;
    logic [19:0] rem_reg;
    logic [4:0]  d_reg;
    logic [3:0]  m_reg;
    logic [15:0] y_reg;
    logic        leap_reg;
    logic        bad_reg;
    logic        ovf_reg;

    logic [4:0]  day_out_reg;
    logic [3:0]  month_out_reg;
    logic [15:0] year_out_reg;
    logic        bad_out_reg;
    logic        ovf_out_reg;

    logic [19:0] amt_ext;
    logic [19:0] rem_load;
    logic [4:0]  cur_len;
    logic [4:0]  nxt_len;
    logic [19:0] day_sum;
    logic [19:0] take;
    logic [3:0]  nm;
    logic [15:0] ny;
    logic        nwrap;
    logic [20:0] year_sum;
    logic        invalid;

    // leap_reg is a registered copy of the leap test of y_reg and only sizes the
    // current month; a day walk always steps through January after a year change
    // before it reaches February
    always_ff @(posedge clk)
    begin
        leap_reg <= cda_pkg::is_leap(y_reg);
    end

    always_comb
    begin
        amt_ext = {4'd0, amount};
        unique case (mode)
            cda_pkg::MODE_WEEKS:   rem_load = (amt_ext << 3) - amt_ext;
            cda_pkg::MODE_DECADES: rem_load = (amt_ext << 3) + (amt_ext << 1);
            default:               rem_load = amt_ext;
        endcase
    end

    always_comb
    begin
        cur_len  = cda_pkg::month_len(m_reg, leap_reg);
        invalid  = (m_reg == 4'd0) || (m_reg > cda_pkg::MONTH_DEC) ||
                   (d_reg == 5'd0) || (d_reg > cur_len);
        day_sum  = {15'd0, d_reg} + rem_reg;
        take     = {15'd0, cur_len} - {15'd0, d_reg} + 20'd1;
        nwrap    = (m_reg == cda_pkg::MONTH_DEC) && (y_reg == cda_pkg::YEAR_MAX);
        if (m_reg == cda_pkg::MONTH_DEC)
        begin
            nm = cda_pkg::MONTH_JAN;
            ny = y_reg + 16'd1;
        end
        else
        begin
            nm = m_reg + 4'd1;
            ny = y_reg;
        end
        // next month is February only from January, so the year is unchanged
        nxt_len  = cda_pkg::month_len(nm, cda_pkg::is_leap(y_reg));
        year_sum = {5'd0, y_reg} + {1'b0, rem_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            rem_reg  <= rem_load;
            d_reg    <= day_in;
            m_reg    <= month_in;
            y_reg    <= year_in;
        end
        if (cmd.check)
        begin
            bad_reg <= invalid;
            ovf_reg <= 1'b0;
            if (!invalid && ((mode_reg == cda_pkg::MODE_YEARS) ||
                             (mode_reg == cda_pkg::MODE_DECADES)))
            begin
                y_reg   <= year_sum[15:0];
                ovf_reg <= |year_sum[20:16];
            end
        end
        if (cmd.day_step)
        begin
            if (sts.day_fit)
            begin
                d_reg <= day_sum[4:0];
            end
            else
            begin
                rem_reg <= rem_reg - take;
                d_reg   <= 5'd1;
                m_reg   <= nm;
                y_reg   <= ny;
                if (nwrap)
                    ovf_reg <= 1'b1;
            end
        end
        if (cmd.month_step)
        begin
            rem_reg <= rem_reg - 20'd1;
            m_reg   <= nm;
            y_reg   <= ny;
            if (d_reg > nxt_len)
                d_reg <= nxt_len;
            if (nwrap)
                ovf_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            day_out_reg   <= d_reg;
            month_out_reg <= m_reg;
            year_out_reg  <= y_reg;
            bad_out_reg   <= bad_reg;
            ovf_out_reg   <= ovf_reg;
        end
    end

    always_comb
    begin
        sts.invalid     = invalid;
        sts.mode_days   = (mode_reg == cda_pkg::MODE_DAYS) ||
                          (mode_reg == cda_pkg::MODE_WEEKS);
        sts.mode_months = (mode_reg == cda_pkg::MODE_MONTHS);
        sts.rem_zero    = (rem_reg == 20'd0);
        sts.rem_one     = (rem_reg == 20'd1);
        sts.day_fit     = (day_sum <= {15'd0, cur_len});
    end

    assign day_out       = day_out_reg;
    assign month_out     = month_out_reg;
    assign year_out      = year_out_reg;
    assign bad_date      = bad_out_reg;
    assign year_overflow = ovf_out_reg;

    a_day_step_valid_day: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.day_step |-> (d_reg != 5'd0) && (d_reg <= cur_len))
        else $error("day step on a day outside the current month");

    a_month_step_valid_month: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.month_step |-> (m_reg != 4'd0) && (m_reg <= cda_pkg::MONTH_DEC))
        else $error("month step on an invalid month");

endmodule

// File: rtl/core/cda_ctrl.sv
`timescale 1ns / 1ps

module cda_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output cda_pkg::cda_cmd_t cmd,
    input  cda_pkg::cda_sts_t sts
);

    cda_pkg::cda_state_t state_reg;
    cda_pkg::cda_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        s_axis_tready  = 1'b0;
        unique case (state_reg)
            cda_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = cda_pkg::ST_PREP;
                end
            end
            // leap flag of the loaded year settles
            cda_pkg::ST_PREP:
            begin
                state_next = cda_pkg::ST_CHECK;
            end
            cda_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                priority if (sts.invalid || sts.rem_zero)
                    state_next = cda_pkg::ST_FIN;
                else if (sts.mode_days)
                    state_next = cda_pkg::ST_DAYS;
                else if (sts.mode_months)
                    state_next = cda_pkg::ST_MONTHS;
                else
                    state_next = cda_pkg::ST_FIN;
            end
            cda_pkg::ST_DAYS:
            begin
                cmd.day_step = 1'b1;
                if (sts.day_fit)
                    state_next = cda_pkg::ST_FIN;
            end
            cda_pkg::ST_MONTHS:
            begin
                cmd.month_step = 1'b1;
                if (sts.rem_one)
                    state_next = cda_pkg::ST_FIN;
            end
            cda_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_axis_tvalid = out_valid_reg;

    a_days_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cda_pkg::ST_DAYS) |-> sts.mode_days)
        else $error("day stepping outside a day or week mode");

    a_months_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cda_pkg::ST_MONTHS) |-> !sts.rem_zero)
        else $error("month stepping with count exhausted");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cda_pkg::ST_FIN))
        else $error("result raised outside the finish state");

endmodule
